>>> rtl/core/rmsn_pkg.sv
// Shared types and constants for the RMS normalizer.
package rmsn_pkg;

  localparam int MaxLen = 8192;
  localparam int CountW = 14;
  localparam logic [31:0] EpsReset = 32'd42950;
  localparam logic [0:0] RegEps = 1'b0;

  typedef struct packed {
    logic        action;
    logic [31:0] sample;
    logic [31:0] weight;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_SQ,
    ST_ACC_ADD,
    ST_DIV,
    ST_EPS,
    ST_INV_DIV,
    ST_SQRT,
    ST_NRM_MUL1,
    ST_NRM_MUL2,
    ST_NRM_MUL3,
    ST_NRM_MUL4,
    ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic sq;
    logic acc;
    logic div_start;
    logic div_step;
    logic eps_add;
    logic inv_start;
    logic sqrt_start;
    logic sqrt_step;
    logic inv_done;
    logic mul1;
    logic mul2;
    logic mul3;
    logic mul4;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic iter_done;
  } status_t;

endpackage

>>> rtl/core/rmsn_datapath.sv
// Datapath: sum of squares, mean divider, inverse, square root, output multiply.
module rmsn_datapath
  import rmsn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  in_item_t  item,
  input  logic [31:0] eps,
  output status_t   status,
  output out_item_t result
);

  logic [31:0] smag, wmag;
  logic        neg;
  logic [63:0] square;
  logic [63:0] square_sum;
  logic [CountW-1:0] element_count;
  logic [31:0] inverse_rms;

  // shared restoring divider / square root registers
  logic [63:0] quo;
  logic [64:0] rem;
  logic [63:0] dvs;
  logic [6:0]  iter;
  logic [63:0] sq_v, sq_r, sq_bit;
  logic [63:0] t_r, lo_r, hi_r;
  logic [32:0] mag;

  logic [31:0] s_in, w_in;
  logic [64:0] sum_ext, rem_sh;
  logic [64:0] ms_ext;
  logic [63:0] sq_trial;

  assign s_in = item.sample;
  assign w_in = item.weight;
  assign sum_ext = {1'b0, square_sum} + {1'b0, square};
  assign rem_sh = {rem[63:0], quo[63]};
  assign ms_ext = {1'b0, quo} + {33'd0, eps};
  assign sq_trial = sq_r + sq_bit;
  assign status.iter_done = (iter == 7'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum <= '0;
      element_count <= '0;
      inverse_rms <= '0;
      iter <= '0;
    end else begin
      if (cmd.load) begin
        smag <= s_in[31] ? (~s_in + 32'd1) : s_in;
        wmag <= w_in[31] ? (~w_in + 32'd1) : w_in;
        neg <= s_in[31] ^ w_in[31];
      end
      if (cmd.sq) square <= {32'd0, smag} * {32'd0, smag};
      if (cmd.acc) begin
        square_sum <= sum_ext[64] ? '1 : sum_ext[63:0];
        if (element_count < CountW'(MaxLen)) element_count <= element_count + 1'b1;
      end
      if (cmd.div_start) begin
        quo <= square_sum;
        rem <= '0;
        dvs <= {{(64-CountW){1'b0}}, element_count};
        iter <= 7'd64;
      end
      if (cmd.inv_start) begin
        // divide (2^64-1) + 1 -> 2^64 / X: load numerator 2^64 as remainder prep
        quo <= '0;
        rem <= 65'd1;
        dvs <= quo;
        iter <= 7'd64;
      end
      if (cmd.div_step) begin
        if (rem_sh >= {1'b0, dvs}) begin
          rem <= rem_sh - {1'b0, dvs};
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[62:0], 1'b0};
        end
        iter <= iter - 7'd1;
      end
      if (cmd.eps_add) begin
        if (element_count == '0) quo <= {32'd0, eps};
        else quo <= ms_ext[64] ? '1 : ms_ext[63:0];
        square_sum <= '0;
        element_count <= '0;
      end
      if (cmd.sqrt_start) begin
        sq_v <= quo;
        sq_r <= '0;
        sq_bit <= 64'h4000_0000_0000_0000;
        iter <= 7'd32;
      end
      if (cmd.sqrt_step) begin
        if (sq_v >= sq_trial) begin
          sq_v <= sq_v - sq_trial;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        iter <= iter - 7'd1;
      end
      if (cmd.inv_done) begin
        // X <= 1 saturates; q = 2^64/X then isqrt
        if (dvs <= 64'd1 || sq_r[63:32] != 32'd0) inverse_rms <= '1;
        else inverse_rms <= sq_r[31:0];
      end
      if (cmd.mul1) t_r <= {32'd0, smag} * {32'd0, inverse_rms};
      if (cmd.mul2) lo_r <= {32'd0, t_r[31:0]} * {32'd0, wmag};
      if (cmd.mul3) hi_r <= {32'd0, t_r[63:32]} * {32'd0, wmag};
      if (cmd.mul4) begin
        // high part at or above 2^32 already exceeds either limit
        if (hi_r[63:32] != '0) mag <= '1;
        else mag <= {1'b0, hi_r[31:0]} + {1'b0, lo_r[63:32]} + {32'd0, lo_r[31]};
      end
      if (cmd.out_load) begin
        if (neg && mag > 33'h0_8000_0000) begin
          result.value <= 32'h8000_0000;
          result.saturated <= 1'b1;
        end else if (!neg && mag > 33'h0_7FFF_FFFF) begin
          result.value <= 32'h7FFF_FFFF;
          result.saturated <= 1'b1;
        end else begin
          result.value <= neg ? (~mag[31:0] + 32'd1) : mag[31:0];
          result.saturated <= 1'b0;
        end
      end
    end
  end

endmodule

>>> rtl/core/rmsn_ctrl.sv
// Controller state machine sequencing the datapath.
module rmsn_ctrl
  import rmsn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     action,
  input  logic     last,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  status_t  status,
  output cmd_t     cmd
);

  state_t state, state_next;
  logic   last_r, last_r_next;
  logic   out_v, out_v_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      last_r <= 1'b0;
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      last_r <= last_r_next;
      out_v <= out_v_next;
    end
  end

  assign out_valid = out_v;

  always_comb begin
    state_next = state;
    last_r_next = last_r;
    out_v_next = out_v && out_stall;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          last_r_next = last;
          state_next = action ? ST_NRM_MUL1 : ST_ACC_SQ;
        end
      end
      ST_ACC_SQ: begin
        cmd.sq = 1'b1;
        state_next = ST_ACC_ADD;
      end
      ST_ACC_ADD: begin
        cmd.acc = 1'b1;
        state_next = last_r ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (!status.iter_done) cmd.div_step = 1'b1;
        else if (last_r) begin
          cmd.div_start = 1'b1;
          last_r_next = 1'b0;
        end else begin
          state_next = ST_EPS;
        end
      end
      ST_EPS: begin
        cmd.eps_add = 1'b1;
        state_next = ST_INV_DIV;
        last_r_next = 1'b1;
      end
      ST_INV_DIV: begin
        if (last_r) begin
          cmd.inv_start = 1'b1;
          last_r_next = 1'b0;
        end else if (!status.iter_done) cmd.div_step = 1'b1;
        else begin
          cmd.sqrt_start = 1'b1;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (!status.iter_done) cmd.sqrt_step = 1'b1;
        else begin
          cmd.inv_done = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_NRM_MUL1: begin
        cmd.mul1 = 1'b1;
        state_next = ST_NRM_MUL2;
      end
      ST_NRM_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = ST_NRM_MUL3;
      end
      ST_NRM_MUL3: begin
        cmd.mul3 = 1'b1;
        state_next = ST_NRM_MUL4;
      end
      ST_NRM_MUL4: begin
        cmd.mul4 = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_v || !out_stall) begin
          cmd.out_load = 1'b1;
          out_v_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/rms_normalizer_top.sv
// RMS normalizer: two-pass vector normalization with APB register for eps.
//
// Input channel (in_valid/in_stall/in_data): accumulate items (action 0)
// add the sample square to a saturating 64-bit sum; the accumulate item
// with last set forms inverse rms = 1/sqrt(sum/count + eps). Normalize
// items (action 1) return sample*inverse_rms*weight, rounded and clipped to
// Q16.16 on out_valid/out_stall/out_data, with a saturated flag.
// Steps per transaction: an accumulate squares and adds; the last accumulate
// then runs a 64-step mean divide, a 64-step reciprocal divide (both on a
// shared shift-subtract divider) and a 32-step root; normalize runs four multiply steps to the output register.
// The output register holds a result while out_stall is high; the next
// input is taken meanwhile but its result waits for the register to empty.
// Reset clears sum, count, inverse rms (so early normalize gives 0), and
// sets eps to 42950. eps is written at APB address 0; write it while idle.
module rms_normalizer_top
  import rmsn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] eps;
  cmd_t        cmd;
  status_t     status;

  assign pready = 1'b1;
  assign prdata = (paddr == RegEps) ? eps : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) eps <= EpsReset;
    else if (psel && penable && pwrite && paddr == RegEps) eps <= pwdata;
  end

  rmsn_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .action(in_data.action),
    .last(in_data.last), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  rmsn_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .item(in_data), .eps(eps),
    .status(status), .result(out_data)
  );

endmodule
